FILE: hdl/b32enc_pkg.sv
// shared types, constants and the alphabet lookup for the base32 stream encoder
package b32enc_pkg;

    localparam int GROUP_BITS = 5;
    localparam int BYTE_BITS  = 8;
    localparam int LEFT_BITS  = 4;
    localparam int ACC_BITS   = LEFT_BITS + BYTE_BITS;

    localparam logic [3:0] GROUP_LEN  = 4'd5;
    localparam logic [3:0] TWO_GROUPS = 4'd10;
    localparam logic [3:0] BYTE_LEN   = 4'd8;
    localparam logic [4:0] LETTERS    = 5'd26;
    localparam logic [7:0] CHAR_A     = 8'h61;
    localparam logic [7:0] CHAR_2     = 8'h32;

    typedef struct packed {
        logic [GROUP_BITS-1:0] idx;
        logic                  eot;
    } t_sym;

    function automatic logic [7:0] alphabet(input logic [GROUP_BITS-1:0] idx);
        logic [7:0] c;
        if (idx < LETTERS) begin
            c = CHAR_A + {3'b000, idx};
        end else begin
            c = CHAR_2 + {3'b000, idx - LETTERS};
        end
        return c;
    endfunction

endpackage

FILE: hdl/b32enc_split.sv
// input register, leftover bit state and 5-bit group selection
module b32enc_split (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [7:0]          i_byte,
    input  logic                i_last,
    output logic                o_sym_valid,
    input  logic                i_sym_ready,
    output b32enc_pkg::t_sym    o_sym
);

    logic                              r_valid;
    logic [b32enc_pkg::ACC_BITS-1:0]   r_acc;
    logic [3:0]                        r_n;
    logic                              r_last;
    logic [b32enc_pkg::LEFT_BITS-1:0]  r_lbits;
    logic [2:0]                        r_lcnt;

    logic [b32enc_pkg::ACC_BITS-1:0]   n_acc;
    logic [3:0]                        n_n;
    logic [3:0]                        n_rem;
    logic [3:0]                        n_mask;
    logic [b32enc_pkg::LEFT_BITS-1:0]  n_lbits;
    logic [2:0]                        n_lcnt;

    logic                              emit;
    logic                              take;
    logic                              pad;
    logic [3:0]                        n_after;
    logic                              done;
    logic [b32enc_pkg::ACC_BITS-1:0]   shifted;
    logic [b32enc_pkg::GROUP_BITS-1:0] padded;
    logic [2:0]                        rsh;
    logic [2:0]                        lsh;

    // item entering: combine with leftover bits and derive the next leftover
    always_comb begin
        n_acc = {r_lbits, i_byte};
        n_n   = {1'b0, r_lcnt} + b32enc_pkg::BYTE_LEN;
        if (n_n >= b32enc_pkg::TWO_GROUPS) begin
            n_rem = n_n - b32enc_pkg::TWO_GROUPS;
        end else begin
            n_rem = n_n - b32enc_pkg::GROUP_LEN;
        end
        n_mask = (4'd1 << n_rem[2:0]) - 4'd1;
        if (i_last) begin
            n_lbits = '0;
            n_lcnt  = '0;
        end else begin
            n_lbits = n_acc[b32enc_pkg::LEFT_BITS-1:0] & n_mask;
            n_lcnt  = n_rem[2:0];
        end
    end

    // group emission from the held item
    always_comb begin
        pad     = (r_n < b32enc_pkg::GROUP_LEN);
        rsh     = 3'(r_n - b32enc_pkg::GROUP_LEN);
        lsh     = 3'(b32enc_pkg::GROUP_LEN - r_n);
        shifted = r_acc >> rsh;
        padded  = r_acc[b32enc_pkg::GROUP_BITS-1:0] << lsh;
        n_after = pad ? 4'd0 : r_n - b32enc_pkg::GROUP_LEN;
        done    = (n_after < b32enc_pkg::GROUP_LEN) && (!r_last || (n_after == 4'd0));
        o_sym.idx = pad ? padded : shifted[b32enc_pkg::GROUP_BITS-1:0];
        o_sym.eot = r_last && done;
    end

    assign o_sym_valid = r_valid;
    assign emit        = r_valid && i_sym_ready;
    assign o_ready     = !r_valid || (emit && done);
    assign take        = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_lbits <= '0;
            r_lcnt  <= '0;
        end else begin
            if (take) begin
                r_valid <= 1'b1;
                r_lbits <= n_lbits;
                r_lcnt  <= n_lcnt;
            end else if (emit && done) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_acc  <= n_acc;
            r_n    <= n_n;
            r_last <= i_last;
        end else if (emit) begin
            r_n <= n_after;
        end
    end

endmodule

FILE: hdl/b32enc_out.sv
// alphabet mapping and output result register
module b32enc_out (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_sym_valid,
    output logic                o_sym_ready,
    input  b32enc_pkg::t_sym    i_sym,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [7:0]          o_char,
    output logic                o_eot
);

    logic       r_valid;
    logic [7:0] r_char;
    logic       r_eot;
    logic       load;

    assign o_sym_ready = !r_valid || i_ready;
    assign load        = i_sym_valid && o_sym_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_sym_ready) begin
            r_valid <= i_sym_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_char <= b32enc_pkg::alphabet(i_sym.idx);
            r_eot  <= i_sym.eot;
        end
    end

    assign o_valid = r_valid;
    assign o_char  = r_char;
    assign o_eot   = r_eot;

endmodule

FILE: hdl/base32_stream_encoder_unit.sv
// top level of the base32 stream encoder
// Bytes enter on the slave stream, most significant bit first, and leave as lowercase
// base32 characters (a-z, 2-7) with no '=' padding; tlast on a byte closes the message,
// the remaining bits are zero padded on the right and the final character carries tlast.
// One character leaves per cycle while m_axis_tready allows; a byte yields one to three
// characters (1.6 on average, two for most bytes); the next byte is taken in the cycle
// its predecessor's last character moves on to the single-character output register.
module base32_stream_encoder_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
    input  logic       s_axis_tlast,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] symbol
    output logic       m_axis_tlast
);

    logic             sym_valid;
    logic             sym_ready;
    b32enc_pkg::t_sym sym;

    b32enc_split u_split (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_byte      (s_axis_tdata),
        .i_last      (s_axis_tlast),
        .o_sym_valid (sym_valid),
        .i_sym_ready (sym_ready),
        .o_sym       (sym)
    );

    b32enc_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_sym_valid (sym_valid),
        .o_sym_ready (sym_ready),
        .i_sym       (sym),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_char      (m_axis_tdata),
        .o_eot       (m_axis_tlast)
    );

endmodule
